// File: hw/rtl/hmq_pkg.sv
`timescale 1ns / 1ps

package hmq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  // Heap levels: slot CAPACITY lives on level LEVELS-1 (1-based slots)
  localparam int LEVELS   = $clog2(CAPACITY + 1);
  localparam int SLOT_W   = LEVELS;
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PIDX_W   = (LEVELS > 2) ? LEVELS - 2 : 1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [PIDX_W-1:0]       pidx_t;

  typedef enum logic [0:0] {
    REQ_INSERT,
    REQ_REMOVE
  } req_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY
  } status_t;

  // Work token that walks down the row of level cells
  typedef struct packed {
    logic  valid;
    logic  remove;   // sift-down of a removal, else top-down insert
    slot_t slot;     // heap slot on the current level
    key_t  carry;    // key still looking for its place
    key_t  node;     // insert: key held at slot
    slot_t last;     // insert: new slot; removal: last valid slot
    slot_t path;     // insert: remaining path bits, MSB first
  } tok_t;

  // Write of one heap slot, split into even and odd halves of a level
  typedef struct packed {
    logic  we;
    logic  odd;
    pidx_t addr;
    key_t  data;
  } wr_t;

endpackage

// File: hw/rtl/hmq_if.sv
`timescale 1ns / 1ps

interface hmq_req_if;
  logic           valid;
  logic           ready;
  hmq_pkg::req_t  req_type;
  hmq_pkg::key_t  key_in;

  modport source (output valid, output req_type, output key_in, input ready);
  modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

interface hmq_res_if;
  logic             valid;
  logic             ready;
  hmq_pkg::key_t    removed_key;
  hmq_pkg::key_t    top_key;
  hmq_pkg::slot_t   entry_count;
  hmq_pkg::status_t status;

  modport source (output valid, output removed_key, output top_key, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input removed_key, input top_key, input entry_count,
                  input status, output ready);
endinterface

// File: hw/rtl/binary_max_heap_queue.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake     Payload
// in_ch    sink       valid/ready   req_type, key_in
// out_ch   source     valid/ready   removed_key, top_key, entry_count, status
//
// One request at a time; a result waits in the output register while the next
// request is taken. A request is accepted, launched into the level cells and
// its result loaded; a removal first fetches the last entry. Each level cell its
// token visits needs a child-pair read and a compare/write. Dropped or trivial
// requests skip the level cells.
// Reset clears the entry count and the control state; heap storage is not cleared.

module binary_max_heap_queue (
  input  logic      clk,
  input  logic      rst_n,
  hmq_req_if.sink   in_ch,
  hmq_res_if.source out_ch
);

  localparam int SLOT_W = hmq_pkg::SLOT_W;
  localparam int LVL_W  = hmq_pkg::LVL_W;
  localparam int LEVELS = hmq_pkg::LEVELS;

  localparam hmq_pkg::slot_t   CAP_SLOT  = hmq_pkg::slot_t'(hmq_pkg::CAPACITY);
  localparam logic [LVL_W:0]   SHIFT_TOP = (LVL_W + 1)'(SLOT_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_RUN,
    S_OUT
  } state_t;

  function automatic int pair_depth(int k);
    int hi;
    int mx;
    int d;
    hi = (1 << (k + 1)) - 1;
    if (hi > hmq_pkg::CAPACITY) begin
      hi = hmq_pkg::CAPACITY;
    end
    mx = (hi - (1 << k)) >> 1;
    d  = 2;
    while (d < mx + 1) begin
      d = d << 1;
    end
    return d;
  endfunction

  function automatic logic [LVL_W-1:0] msb_pos(hmq_pkg::slot_t v);
    logic [LVL_W-1:0] p;
    p = '0;
    for (int i = 0; i < SLOT_W; i++) begin
      if (v[i]) begin
        p = LVL_W'(i);
      end
    end
    return p;
  endfunction

  state_t           st_r;
  hmq_pkg::slot_t   cnt_r;
  hmq_pkg::key_t    root_r;
  hmq_pkg::key_t    rem_r;
  hmq_pkg::status_t status_r;
  logic [LVL_W-1:0] lvl_r;
  logic             half_r;
  hmq_pkg::tok_t    launch_r;

  logic             out_valid_r;
  hmq_pkg::key_t    out_rem_r;
  hmq_pkg::key_t    out_top_r;
  hmq_pkg::slot_t   out_cnt_r;
  hmq_pkg::status_t out_status_r;

  hmq_pkg::tok_t    tok_w [LEVELS+1];
  hmq_pkg::wr_t     wr_w  [LEVELS];
  hmq_pkg::pidx_t   rdq_w [LEVELS];
  hmq_pkg::key_t    ev_d  [LEVELS];
  hmq_pkg::key_t    od_d  [LEVELS];
  logic [LEVELS-1:0] done_w;

  logic             accept;
  logic             out_load;
  logic             done_any;
  hmq_pkg::slot_t   ins_slot;
  logic [LVL_W-1:0] ins_lvl;
  logic [LVL_W:0]   path_amt;
  hmq_pkg::slot_t   ins_path;
  logic [LVL_W-1:0] last_lvl;
  hmq_pkg::slot_t   last_base;
  hmq_pkg::slot_t   fetch_full;
  hmq_pkg::pidx_t   fetch_idx;
  hmq_pkg::key_t    fetched;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_load     = (st_r == S_OUT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.removed_key = out_rem_r;
  assign out_ch.top_key     = out_top_r;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.status      = out_status_r;

  assign tok_w[0] = launch_r;
  assign ev_d[0]  = '0;
  assign od_d[0]  = '0;

  always_comb begin
    ins_slot   = cnt_r + hmq_pkg::slot_t'(1);
    ins_lvl    = msb_pos(ins_slot);
    // left-align the path bits below the leading one
    path_amt   = SHIFT_TOP - {1'b0, ins_lvl};
    ins_path   = ins_slot << path_amt;

    last_lvl   = msb_pos(cnt_r);
    last_base  = hmq_pkg::slot_t'(1) << last_lvl;
    fetch_full = (cnt_r & ~last_base) >> 1;
    fetch_idx  = fetch_full[hmq_pkg::PIDX_W-1:0];

    fetched    = half_r ? od_d[lvl_r] : ev_d[lvl_r];

    done_any   = (|done_w) || tok_w[LEVELS].valid;
  end

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    localparam hmq_pkg::slot_t LVL_MASK = hmq_pkg::slot_t'(1) << k;
    hmq_pkg::key_t kid_ev;
    hmq_pkg::key_t kid_od;

    if (k < LEVELS - 1) begin : g_mid
      assign kid_ev = ev_d[k+1];
      assign kid_od = od_d[k+1];
    end else begin : g_end
      assign kid_ev = '0;
      assign kid_od = '0;
    end

    hmq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lvl_mask (LVL_MASK),
      .tok_i    (tok_w[k]),
      .tok_o    (tok_w[k+1]),
      .rd_addr  (rdq_w[k]),
      .rd_even  (kid_ev),
      .rd_odd   (kid_od),
      .wr       (wr_w[k]),
      .done     (done_w[k])
    );
  end

  // Level j storage: even and odd slots, indexed by the parent's position
  for (genvar j = 1; j < LEVELS; j++) begin : g_mem
    localparam int D  = pair_depth(j);
    localparam int AW = $clog2(D);
    logic [AW-1:0] ra;
    logic [AW-1:0] wa;
    logic          we_e;
    logic          we_o;

    // while idle the read ports serve the last-entry fetch
    assign ra   = (st_r == S_IDLE) ? fetch_idx[AW-1:0] : rdq_w[j-1][AW-1:0];
    assign wa   = wr_w[j].addr[AW-1:0];
    assign we_e = wr_w[j].we && !wr_w[j].odd;
    assign we_o = wr_w[j].we && wr_w[j].odd;

    hmq_ram #(.DEPTH(D), .WIDTH(hmq_pkg::KEY_W)) u_even (
      .clk   (clk),
      .we    (we_e),
      .waddr (wa),
      .wdata (wr_w[j].data),
      .raddr (ra),
      .rdata (ev_d[j])
    );

    hmq_ram #(.DEPTH(D), .WIDTH(hmq_pkg::KEY_W)) u_odd (
      .clk   (clk),
      .we    (we_o),
      .waddr (wa),
      .wdata (wr_w[j].data),
      .raddr (ra),
      .rdata (od_d[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= S_IDLE;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
      launch_r.valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_w[0].we) begin
        root_r <= wr_w[0].data;
      end

      unique case (st_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_ch.req_type)
              hmq_pkg::REQ_INSERT: begin
                rem_r <= '0;
                if (cnt_r == CAP_SLOT) begin
                  status_r <= hmq_pkg::ST_FULL;
                  st_r     <= S_OUT;
                end else begin
                  status_r <= hmq_pkg::ST_OK;
                  cnt_r    <= ins_slot;
                  if (cnt_r == '0) begin
                    root_r <= in_ch.key_in;
                    st_r   <= S_OUT;
                  end else begin
                    launch_r <= '{valid:  1'b1,
                                  remove: 1'b0,
                                  slot:   hmq_pkg::slot_t'(1),
                                  carry:  in_ch.key_in,
                                  node:   root_r,
                                  last:   ins_slot,
                                  path:   ins_path};
                    st_r     <= S_RUN;
                  end
                end
              end
              hmq_pkg::REQ_REMOVE: begin
                if (cnt_r == '0) begin
                  status_r <= hmq_pkg::ST_EMPTY;
                  rem_r    <= '0;
                  st_r     <= S_OUT;
                end else begin
                  status_r <= hmq_pkg::ST_OK;
                  rem_r    <= root_r;
                  cnt_r    <= cnt_r - hmq_pkg::slot_t'(1);
                  if (cnt_r == hmq_pkg::slot_t'(1)) begin
                    st_r <= S_OUT;
                  end else begin
                    lvl_r  <= last_lvl;
                    half_r <= cnt_r[0];
                    st_r   <= S_FETCH;
                  end
                end
              end
              default: begin
                status_r <= hmq_pkg::ST_OK;
                rem_r    <= '0;
                st_r     <= S_OUT;
              end
            endcase
          end
        end
        S_FETCH: begin
          // last entry restarts the sift-down from the root
          launch_r <= '{valid:  1'b1,
                        remove: 1'b1,
                        slot:   hmq_pkg::slot_t'(1),
                        carry:  fetched,
                        node:   '0,
                        last:   cnt_r,
                        path:   '0};
          st_r     <= S_RUN;
        end
        S_RUN: begin
          launch_r.valid <= 1'b0;
          if (done_any) begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_rem_r    <= rem_r;
            out_top_r    <= (cnt_r == '0) ? '0 : root_r;
            out_cnt_r    <= cnt_r;
            out_status_r <= status_r;
            st_r         <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/hmq_ram.sv
`timescale 1ns / 1ps

module hmq_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/hmq_cell.sv
`timescale 1ns / 1ps

module hmq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  hmq_pkg::slot_t lvl_mask,
  input  hmq_pkg::tok_t  tok_i,
  output hmq_pkg::tok_t  tok_o,
  output hmq_pkg::pidx_t rd_addr,
  input  hmq_pkg::key_t  rd_even,
  input  hmq_pkg::key_t  rd_odd,
  output hmq_pkg::wr_t   wr,
  output logic           done
);

  hmq_pkg::tok_t  tok_r;
  logic           phb_r;

  hmq_pkg::slot_t           sub_idx;
  hmq_pkg::slot_t           half_idx;
  logic [hmq_pkg::SLOT_W:0] kid_l;
  logic [hmq_pkg::SLOT_W:0] kid_r;
  logic [hmq_pkg::SLOT_W:0] last_x;
  logic [hmq_pkg::SLOT_W:0] kid_slot;
  logic                     l_ok;
  logic                     r_ok;
  logic                     pick_r;
  logic                     path_bit;
  logic                     step_b;
  hmq_pkg::key_t            kid_key;

  // Phase A issues the child read, phase B decides and hands the token on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      phb_r       <= 1'b0;
    end else if (tok_i.valid) begin
      tok_r <= tok_i;
      phb_r <= 1'b0;
    end else if (tok_r.valid) begin
      phb_r <= ~phb_r;
      if (phb_r) begin
        tok_r.valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sub_idx  = tok_r.slot & (lvl_mask - hmq_pkg::slot_t'(1));
    half_idx = sub_idx >> 1;
    rd_addr  = sub_idx[hmq_pkg::PIDX_W-1:0];
    step_b   = tok_r.valid && phb_r;

    kid_l    = {tok_r.slot, 1'b0};
    kid_r    = {tok_r.slot, 1'b1};
    last_x   = {1'b0, tok_r.last};
    l_ok     = (kid_l <= last_x);
    r_ok     = (kid_r <= last_x);
    // right child only when strictly larger
    pick_r   = r_ok && (rd_even < rd_odd);
    kid_key  = pick_r ? rd_odd : rd_even;
    kid_slot = pick_r ? kid_r : kid_l;
    path_bit = tok_r.path[hmq_pkg::SLOT_W-1];

    wr.we    = 1'b0;
    wr.odd   = tok_r.slot[0];
    wr.addr  = half_idx[hmq_pkg::PIDX_W-1:0];
    wr.data  = tok_r.carry;

    tok_o       = tok_r;
    tok_o.valid = 1'b0;
    done        = 1'b0;

    if (step_b) begin
      if (tok_r.remove) begin
        wr.we = 1'b1;
        if (l_ok && (tok_r.carry < kid_key)) begin
          // pull the larger child up, keep sinking the carried key
          wr.data     = kid_key;
          tok_o.valid = 1'b1;
          tok_o.slot  = kid_slot[hmq_pkg::SLOT_W-1:0];
        end else begin
          done = 1'b1;
        end
      end else if (tok_r.slot == tok_r.last) begin
        wr.we = 1'b1;
        done  = 1'b1;
      end else begin
        if (tok_r.carry > tok_r.node) begin
          // take the slot, displace the old key downward
          wr.we       = 1'b1;
          tok_o.carry = tok_r.node;
        end
        tok_o.valid = 1'b1;
        tok_o.slot  = {tok_r.slot[hmq_pkg::SLOT_W-2:0], path_bit};
        tok_o.node  = path_bit ? rd_odd : rd_even;
        tok_o.path  = tok_r.path << 1;
      end
    end
  end

endmodule
